// ===== hdl/aosa_pkg.sv =====
`timescale 1ns / 1ps
// aosa_pkg: shared types and constants of the oversampling scan averager
// no dependencies; imported by aosa_rr_pick and adc_oversampling_scan_averager
package aosa_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int CH_W         = 3;
  localparam int SAMPLE_BITS  = 10;
  localparam int RATE_W       = 3;
  localparam int CNT_W        = 11;
  localparam int SUM_W        = 20;
  localparam int AVG_W        = 15;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  localparam logic [RATE_W-1:0] MAX_RATE = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCAN_ENABLE  = 2'd0,
    CFG_CHANNEL_MASK = 2'd1,
    CFG_OVERSAMPLE   = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_READ   = 1'b1
  } action_t;

  typedef struct packed {
    logic                   action;
    logic [SAMPLE_BITS-1:0] sample;
    logic [CH_W-1:0]        read_channel;
  } in_t;

  typedef struct packed {
    logic                    done_res;
    logic [CH_W-1:0]         done_channel;
    logic [AVG_W-1:0]        average;
    logic [NUM_CHANNELS-1:0] ready_mask;
    logic [CH_W-1:0]         current_channel;
    logic [AVG_W-1:0]        read_value;
  } out_t;

endpackage

// ===== hdl/aosa_rr_pick.sv =====
`timescale 1ns / 1ps
// aosa_rr_pick: round-robin channel selection over the scan mask
// depends on aosa_pkg
module aosa_rr_pick (
  input  logic [aosa_pkg::NUM_CHANNELS-1:0] mask,
  input  logic [aosa_pkg::CH_W-1:0]         cur_chan,
  output logic [aosa_pkg::CH_W-1:0]         next_chan,
  output logic [aosa_pkg::CH_W-1:0]         low_chan
);
  import aosa_pkg::*;

  // next masked channel above cur_chan, wrapping; stays put if none other
  always_comb begin
    logic [CH_W-1:0] cand;
    next_chan = cur_chan;
    for (int i = NUM_CHANNELS - 1; i >= 1; i--) begin
      cand = cur_chan + CH_W'(i);
      if (mask[cand]) begin
        next_chan = cand;
      end
    end
  end

  // lowest masked channel, 0 for an empty mask
  always_comb begin
    low_chan = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        low_chan = CH_W'(i);
      end
    end
  end

endmodule

// ===== hdl/adc_oversampling_scan_averager.sv =====
`timescale 1ns / 1ps
// adc_oversampling_scan_averager: top level of the oversampling scan averager
// depends on aosa_pkg and aosa_rr_pick
//
// Usage:
//   in_*  : one transfer per converter sample (action = sample) or per read
//           of a stored channel average (action = read).
//   out_* : exactly one result per input transfer, in order. It carries the
//           completion flag, channel and average, the ready mask, the channel
//           the multiplexer should sample next and the read value.
//   cfg_* : register writes (scan enable, channel mask, oversample rate),
//           always ready; issue them only while no results are pending.
//           Writing scan enable = 1 restarts the scan and clears the stores
//           of the masked channels in that same cycle.
// The result is valid in the cycle after the input transfer. Throughput is one
// item per cycle while the receiver does not stall: accumulate, threshold compare
// and next-channel pick all complete between the input and the result register.
// Reset (rst_n low, synchronous) clears state registers, sums, averages and flags;
// the result data register is not reset. When the receiver stalls, the result
// register holds and in_ready drops; a result taken in the same cycle lets a new item in.
module adc_oversampling_scan_averager (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  aosa_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output aosa_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [aosa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aosa_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import aosa_pkg::*;

  logic                    scan_en_r;
  logic [NUM_CHANNELS-1:0] mask_r;
  logic [RATE_W-1:0]       rate_r;
  logic [CH_W-1:0]         chan_r;
  logic [CNT_W-1:0]        count_r;
  logic [SUM_W-1:0]        sums_r [NUM_CHANNELS];
  logic [AVG_W-1:0]        avgs_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] ready_r;
  logic                    out_valid_r;
  out_t                    out_data_r;

  logic              in_xfer;
  logic              cfg_xfer;
  logic              restart;
  logic              do_sample;
  logic [RATE_W-1:0] rate_eff;
  logic [CNT_W-1:0]  count_nxt;
  logic [CNT_W-1:0]  thresh;
  logic [SUM_W-1:0]  sum_nxt;
  logic [AVG_W-1:0]  avg;
  logic              done;
  logic [CH_W-1:0]   next_chan;
  logic [CH_W-1:0]   low_chan;
  out_t              res;

  aosa_rr_pick u_pick (
    .mask      (mask_r),
    .cur_chan  (chan_r),
    .next_chan (next_chan),
    .low_chan  (low_chan)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid;
  assign restart   = cfg_xfer && (cfg_idx_t'(cfg_index) == CFG_SCAN_ENABLE) && cfg_data[0];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign do_sample = in_xfer && (action_t'(in_data.action) == ACT_SAMPLE) && scan_en_r;
  assign rate_eff  = (rate_r > MAX_RATE) ? MAX_RATE : rate_r;
  assign count_nxt = count_r + CNT_W'(1);
  assign thresh    = CNT_W'(1) << {rate_eff, 1'b0};
  // the settling sample (count zero) is not summed
  assign sum_nxt   = (count_r != '0) ? sums_r[chan_r] + SUM_W'(in_data.sample)
                                     : sums_r[chan_r];
  assign avg       = AVG_W'(sum_nxt >> rate_eff);
  assign done      = count_nxt > thresh;

  always_comb begin
    res                 = '0;
    res.ready_mask      = ready_r;
    res.current_channel = chan_r;
    if (action_t'(in_data.action) == ACT_READ) begin
      if (mask_r[in_data.read_channel]) begin
        res.read_value = avgs_r[in_data.read_channel];
      end
    end else if (scan_en_r && done) begin
      res.done_res        = 1'b1;
      res.done_channel    = chan_r;
      res.average         = avg;
      res.ready_mask      = ready_r | (NUM_CHANNELS'(1) << chan_r);
      res.current_channel = next_chan;
    end
  end

  // configuration and scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_en_r <= 1'b0;
      mask_r    <= '0;
      rate_r    <= '0;
      chan_r    <= '0;
      count_r   <= '0;
      ready_r   <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sums_r[i] <= '0;
        avgs_r[i] <= '0;
      end
    end else if (cfg_xfer) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SCAN_ENABLE:  scan_en_r <= cfg_data[0];
        CFG_CHANNEL_MASK: mask_r    <= cfg_data;
        CFG_OVERSAMPLE:   rate_r    <= cfg_data[RATE_W-1:0];
        default:          ;
      endcase
      if (restart) begin
        count_r <= '0;
        ready_r <= '0;
        chan_r  <= low_chan;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (mask_r[i]) begin
            sums_r[i] <= '0;
            avgs_r[i] <= '0;
          end
        end
      end
    end else if (do_sample) begin
      if (done) begin
        sums_r[chan_r] <= '0;
        avgs_r[chan_r] <= avg;
        count_r        <= '0;
        ready_r        <= res.ready_mask;
        chan_r         <= next_chan;
      end else begin
        sums_r[chan_r] <= sum_nxt;
        count_r        <= count_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= res;
    end
  end

endmodule
